>>> rtl/drd_pkg.sv
// Shared types and constants of the detection row decoder.
package drd_pkg;

    localparam int MAX_ROW_LENGTH = 128;
    localparam int MIN_ROW_LENGTH = 6;
    localparam int FIRST_CLASS_POS = 5;

    localparam int VALUE_W = 16;
    localparam int POS_W   = 7;
    localparam int LEN_W   = 8;
    localparam int SCALE_W = 13;
    localparam int CORNER_W = 15;
    localparam int CLASS_W = 7;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SCALE     = 2'd2;

    localparam logic [VALUE_W-1:0] RESET_THRESHOLD  = 16'd8192;
    localparam logic [LEN_W-1:0]   RESET_ROW_LENGTH = 8'd85;
    localparam logic [SCALE_W-1:0] RESET_SCALE      = 13'd640;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One accepted row that passed the threshold test, waiting for the math.
    typedef struct packed {
        logic [VALUE_W-1:0] center_x;
        logic [VALUE_W-1:0] center_y;
        logic [VALUE_W-1:0] box_width;
        logic [VALUE_W-1:0] box_height;
        logic [VALUE_W-1:0] objectness;
        logic [VALUE_W-1:0] class_score;
        logic [CLASS_W-1:0] class_index;
    } t_job;

endpackage

>>> rtl/drd_front.sv
// Row parser: tracks the element position, the box fields and the best class.
module drd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [drd_pkg::VALUE_W-1:0] i_value,
    input  logic [drd_pkg::VALUE_W-1:0] i_threshold,
    input  logic [drd_pkg::LEN_W-1:0]   i_row_length,
    output logic                        o_push,
    output drd_pkg::t_job               o_job
);

    logic [drd_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [drd_pkg::VALUE_W-1:0] r_cx, r_cy, r_w, r_h, r_obj, r_best;
    logic [drd_pkg::VALUE_W-1:0] n_cx, n_cy, n_w, n_h, n_obj, n_best;
    logic [drd_pkg::CLASS_W-1:0] r_cls, n_cls;
    logic [drd_pkg::LEN_W-1:0]   len;
    logic [drd_pkg::LEN_W-1:0]   pos_plus;
    logic                        row_end;

    always_comb begin
        if (i_row_length < drd_pkg::LEN_W'(drd_pkg::MIN_ROW_LENGTH)) begin
            len = drd_pkg::LEN_W'(drd_pkg::MIN_ROW_LENGTH);
        end else if (i_row_length > drd_pkg::LEN_W'(drd_pkg::MAX_ROW_LENGTH)) begin
            len = drd_pkg::LEN_W'(drd_pkg::MAX_ROW_LENGTH);
        end else begin
            len = i_row_length;
        end
    end

    assign pos_plus = {1'b0, r_pos} + drd_pkg::LEN_W'(1);
    assign row_end  = pos_plus >= len;

    // Values after the current element is taken in.
    always_comb begin
        n_cx   = r_cx;
        n_cy   = r_cy;
        n_w    = r_w;
        n_h    = r_h;
        n_obj  = r_obj;
        n_best = r_best;
        n_cls  = r_cls;
        case (r_pos)
            7'd0:    n_cx  = i_value;
            7'd1:    n_cy  = i_value;
            7'd2:    n_w   = i_value;
            7'd3:    n_h   = i_value;
            7'd4:    n_obj = i_value;
            default: begin
                if (i_value > r_best) begin
                    n_best = i_value;
                    n_cls  = r_pos - drd_pkg::POS_W'(drd_pkg::FIRST_CLASS_POS);
                end
            end
        endcase
        n_pos = row_end ? '0 : pos_plus[drd_pkg::POS_W-1:0];
    end

    assign o_push = i_accept && row_end &&
                    (n_obj >= i_threshold) && (n_best >= i_threshold);

    always_comb begin
        o_job.center_x    = n_cx;
        o_job.center_y    = n_cy;
        o_job.box_width   = n_w;
        o_job.box_height  = n_h;
        o_job.objectness  = n_obj;
        o_job.class_score = n_best;
        o_job.class_index = n_cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_w    <= '0;
            r_h    <= '0;
            r_obj  <= '0;
            r_best <= '0;
            r_cls  <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_w   <= n_w;
            r_h   <= n_h;
            r_obj <= n_obj;
            if (row_end) begin
                r_best <= '0;
                r_cls  <= '0;
            end else begin
                r_best <= n_best;
                r_cls  <= n_cls;
            end
        end
    end

endmodule

>>> rtl/drd_queue.sv
// Small first-in first-out queue of passed rows between parser and math.
module drd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  drd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output drd_pkg::t_job o_job
);

    drd_pkg::t_job                r_mem [drd_pkg::QUEUE_DEPTH];
    logic [drd_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [drd_pkg::QUEUE_AW:0]   r_count;
    logic                         do_push, do_pop;

    assign o_full  = r_count == (drd_pkg::QUEUE_AW+1)'(drd_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + drd_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + drd_pkg::QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (drd_pkg::QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (drd_pkg::QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/drd_back.sv
// Box math: corner products and score in one stage, saturation and output in the next.
module drd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [drd_pkg::SCALE_W-1:0]       i_scale,
    input  logic                              i_job_valid,
    input  drd_pkg::t_job                     i_job,
    output logic                              o_job_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [drd_pkg::OUT_DATA_W-1:0]    o_tdata
);

    localparam int NUM_W  = 19;
    localparam int MAG_W  = 18;
    localparam int PROD_W = MAG_W + drd_pkg::SCALE_W;

    logic                        r_v1;
    logic [PROD_W-1:0]           r_prod [4];
    logic [3:0]                  r_neg;
    logic [2*drd_pkg::VALUE_W-1:0] r_sprod;
    logic [drd_pkg::CLASS_W-1:0] r_cls;

    logic                        r_ov;
    logic [drd_pkg::OUT_DATA_W-1:0] r_out;

    logic                        out_free, load1;
    logic signed [NUM_W-1:0]     num [4];
    logic [MAG_W-1:0]            mag [4];
    logic [drd_pkg::CORNER_W-1:0] corner [4];
    logic [drd_pkg::CORNER_W-1:0] quot [4];
    logic [drd_pkg::VALUE_W:0]   sq;
    logic [drd_pkg::VALUE_W-1:0] score;

    assign out_free  = !r_ov || i_tready;
    assign load1     = !r_v1 || out_free;
    assign o_job_pop = load1 && i_job_valid;

    // Lanes: 0 left, 1 top, 2 right, 3 bottom.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [drd_pkg::VALUE_W-1:0] c, s;
            c = i[0] ? i_job.center_y : i_job.center_x;
            s = i[0] ? i_job.box_height : i_job.box_width;
            if (i[1]) begin
                num[i] = $signed({2'b00, c, 1'b0}) + $signed({3'b000, s});
            end else begin
                num[i] = $signed({2'b00, c, 1'b0}) - $signed({3'b000, s});
            end
            mag[i] = num[i][NUM_W-1] ? MAG_W'(-num[i]) : num[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= mag[i] * i_scale;
                r_neg[i]  <= num[i][NUM_W-1];
            end
            r_sprod <= i_job.objectness * i_job.class_score;
            r_cls   <= i_job.class_index;
        end
    end

    // Shift down by 16, then clamp to the 15-bit signed range.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            quot[i] = r_prod[i][PROD_W-1:16];
            if (r_neg[i]) begin
                corner[i] = (quot[i] > 15'd16384) ? 15'h4000 : -quot[i];
            end else begin
                corner[i] = (quot[i] > 15'd16383) ? 15'h3FFF : quot[i];
            end
        end
        sq    = r_sprod[2*drd_pkg::VALUE_W-1:15];
        score = sq[drd_pkg::VALUE_W] ? '1 : sq[drd_pkg::VALUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && out_free) begin
            r_out <= {5'b00000, r_cls, score, corner[3], corner[2], corner[1], corner[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= i_job_valid;
            end
            if (out_free) begin
                r_ov <= r_v1;
            end
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_out;

endmodule

>>> rtl/detection_row_decoder.sv
// Top level of the detection row decoder: configuration registers and the three parts.
//
// The block reads detector output one Q1.15 element per request on the slave
// stream, row by row: center x, center y, width, height, objectness, then class
// scores. It keeps the best class (a strictly larger score wins, so the lowest
// index wins ties) and, at the last element of a row, sends one box on the
// master stream if both objectness and the best class score are at least the
// score threshold; rejected rows give nothing. One element is taken every
// clock cycle unless the input stalls: the row parser finishes its work in
// the cycle of the request. Passed rows go into a four-entry queue, and the
// box math behind it is a two-stage pipeline (corner and score multipliers,
// then shift and clamp into the output register). Since rows are at least
// six elements long, the input stalls only when six boxes are held back by
// the master side: four in the queue and one in each of the two math stages.
// The configuration registers are meant to be written while no row is in
// flight; row length is clamped to 6..128, and a shorter length written
// mid-row that the row has already reached ends it at the next element.
module detection_row_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_wr_en,
    input  logic [drd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // Slave stream: tdata = value[15:0].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [drd_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Master stream: tdata = x_left[14:0], y_top[29:15], x_right[44:30],
    // y_bottom[59:45], score[75:60], class_index[82:76], zeros[87:83].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [drd_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic [drd_pkg::VALUE_W-1:0] r_threshold;
    logic [drd_pkg::LEN_W-1:0]   r_row_length;
    logic [drd_pkg::SCALE_W-1:0] r_scale;

    logic          accept;
    logic          push;
    drd_pkg::t_job front_job;
    drd_pkg::t_job queue_job;
    logic          queue_full, queue_valid, queue_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= drd_pkg::RESET_THRESHOLD;
            r_row_length <= drd_pkg::RESET_ROW_LENGTH;
            r_scale      <= drd_pkg::RESET_SCALE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                drd_pkg::CFG_SCORE_THRESHOLD: r_threshold  <= i_cfg_wdata;
                drd_pkg::CFG_ROW_LENGTH:
                    r_row_length <= i_cfg_wdata[drd_pkg::LEN_W-1:0];
                drd_pkg::CFG_IMAGE_SCALE:
                    r_scale <= i_cfg_wdata[drd_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // A request is taken whenever the queue has room for a possible box.
    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    drd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_value      (s_axis_tdata),
        .i_threshold  (r_threshold),
        .i_row_length (r_row_length),
        .o_push       (push),
        .o_job        (front_job)
    );

    drd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    drd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scale     (r_scale),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

>>> bench/tb_detection_row_decoder.sv
// Self-checking testbench for the detection row decoder: directed and random rows.
`timescale 1ns / 1ps

// The bench streams detector rows into the slave port and checks every box on
// the master port against its own model of the decoder. That model follows
// each accepted request and each register write at the clock edge where the
// block sees it, and keeps the boxes it expects in arrival order.
//
// The run is a sequence of phases. Registers change only between phases, after
// the sender has paused until every expected box has come out and a settling
// wait has passed. The first phases are directed:
//   - maximum values, which saturate the score and the right corner;
//   - objectness and class score exactly at the threshold;
//   - rows rejected by objectness alone and by class score alone;
//   - a zero threshold with no class above zero, and a zero image scale;
//   - tied class scores, where the lowest index must win;
//   - a row length above the limit and one below the minimum;
//   - a row cut short by a smaller row length written mid-row.
// Random phases then pick new settings (extremes included) and send rows whose
// scores crowd around the threshold, with a share of fully random rows and
// rows that stop partway through a phase.
module tb_detection_row_decoder;

    localparam int CLOCK_PERIOD    = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TOTAL_ELEMENTS  = 1850;
    localparam int PAD_W = drd_pkg::OUT_DATA_W - drd_pkg::CLASS_W - drd_pkg::VALUE_W
                           - 4 * drd_pkg::CORNER_W;

    // Element positions within a row.
    localparam int POS_CENTER_X   = 0;
    localparam int POS_CENTER_Y   = 1;
    localparam int POS_BOX_WIDTH  = 2;
    localparam int POS_BOX_HEIGHT = 3;
    localparam int POS_OBJECTNESS = 4;

    // Behaviors of the master-side ready pattern.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SLOW,
        READY_STALL_RUNS
    } t_ready_mode;

    // One box as it appears on m_axis_tdata, x_left in the lowest bits.
    typedef struct packed {
        logic [PAD_W-1:0]             pad;
        logic [drd_pkg::CLASS_W-1:0]  class_index;
        logic [drd_pkg::VALUE_W-1:0]  score;
        logic [drd_pkg::CORNER_W-1:0] y_bottom;
        logic [drd_pkg::CORNER_W-1:0] x_right;
        logic [drd_pkg::CORNER_W-1:0] y_top;
        logic [drd_pkg::CORNER_W-1:0] x_left;
    } t_box;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_wr_en = 1'b0;
    logic [drd_pkg::CFG_INDEX_W-1:0] i_cfg_index = drd_pkg::CFG_SCORE_THRESHOLD;
    logic [drd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // tdata = value[15:0].
    logic [drd_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // tdata = x_left[14:0], y_top[29:15], x_right[44:30], y_bottom[59:45],
    // score[75:60], class_index[82:76], zeros[87:83].
    logic [drd_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    detection_row_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLOCK_PERIOD / 2) i_clk = ~i_clk;

    // Elements waiting to be sent, filled by the phase sequencer below.
    logic [drd_pkg::VALUE_W-1:0] element_queue[$];
    int                          queued_elements = 0;

    // Boxes the decoder model expects, oldest first.
    t_box expected_boxes[$];
    int   mismatch_count = 0;
    int   boxes_checked = 0;

    // Decoder model: register copies and row state.
    logic [drd_pkg::VALUE_W-1:0] threshold_reg;
    logic [drd_pkg::LEN_W-1:0]   row_length_reg;
    logic [drd_pkg::SCALE_W-1:0] scale_reg;
    logic [drd_pkg::POS_W-1:0]   element_pos;
    logic [drd_pkg::VALUE_W-1:0] center_x;
    logic [drd_pkg::VALUE_W-1:0] center_y;
    logic [drd_pkg::VALUE_W-1:0] box_width;
    logic [drd_pkg::VALUE_W-1:0] box_height;
    logic [drd_pkg::VALUE_W-1:0] objectness;
    logic [drd_pkg::VALUE_W-1:0] best_score;
    logic [drd_pkg::CLASS_W-1:0] best_class;

    // Settings of the current phase, as the stimulus side sees them.
    logic [drd_pkg::VALUE_W-1:0] phase_threshold;
    int                          phase_row_length;

    task automatic report_mismatch(input string detail);
        mismatch_count++;
        $display("mismatch at %0t ns, box %0d: %s", $time, boxes_checked, detail);
    endtask

    task automatic check_field(input string name, input longint want, input longint seen);
        if (want != seen) begin
            report_mismatch($sformatf("%s expected %0d, got %0d", name, want, seen));
        end
    endtask

    // One box corner: (2c -/+ size) * scale / 65536, truncated toward zero,
    // then clamped to the 15-bit signed range.
    function automatic logic [drd_pkg::CORNER_W-1:0] corner_pixels(
                                               input logic [drd_pkg::VALUE_W-1:0] center,
                                               input logic [drd_pkg::VALUE_W-1:0] size,
                                               input bit plus);
        longint numerator;
        longint pixels;
        numerator = 2 * longint'(center) + (plus ? longint'(size) : -longint'(size));
        if (numerator < 0) begin
            pixels = ((-numerator) * longint'(scale_reg)) >> 16;
            pixels = (pixels > 16384) ? -16384 : -pixels;
        end else begin
            pixels = (numerator * longint'(scale_reg)) >> 16;
            if (pixels > 16383) begin
                pixels = 16383;
            end
        end
        return pixels[drd_pkg::CORNER_W-1:0];
    endfunction

    task automatic apply_register(input logic [drd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [drd_pkg::CFG_DATA_W-1:0] data);
        case (index)
            drd_pkg::CFG_SCORE_THRESHOLD: begin
                threshold_reg = data[drd_pkg::VALUE_W-1:0];
            end
            drd_pkg::CFG_ROW_LENGTH: begin
                row_length_reg = data[drd_pkg::LEN_W-1:0];
            end
            drd_pkg::CFG_IMAGE_SCALE: begin
                scale_reg = data[drd_pkg::SCALE_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Advances the row state by one element and queues a box when the row
    // ends with both scores at or above the threshold.
    task automatic decode_element(input logic [drd_pkg::VALUE_W-1:0] value);
        int     row_end;
        longint product;
        t_box   box;
        row_end = int'(row_length_reg);
        if (row_end < drd_pkg::MIN_ROW_LENGTH) begin
            row_end = drd_pkg::MIN_ROW_LENGTH;
        end else if (row_end > drd_pkg::MAX_ROW_LENGTH) begin
            row_end = drd_pkg::MAX_ROW_LENGTH;
        end
        case (int'(element_pos))
            POS_CENTER_X:   center_x = value;
            POS_CENTER_Y:   center_y = value;
            POS_BOX_WIDTH:  box_width = value;
            POS_BOX_HEIGHT: box_height = value;
            POS_OBJECTNESS: objectness = value;
            default: begin
                // Strictly greater wins, so the lowest index keeps a tie.
                if (value > best_score) begin
                    best_score = value;
                    best_class = element_pos - drd_pkg::POS_W'(drd_pkg::FIRST_CLASS_POS);
                end
            end
        endcase
        if (int'(element_pos) + 1 >= row_end) begin
            if (objectness >= threshold_reg && best_score >= threshold_reg) begin
                product = (longint'(objectness) * longint'(best_score)) >> 15;
                if (product > 65535) begin
                    product = 65535;
                end
                box = '0;
                box.x_left      = corner_pixels(center_x, box_width, 1'b0);
                box.y_top       = corner_pixels(center_y, box_height, 1'b0);
                box.x_right     = corner_pixels(center_x, box_width, 1'b1);
                box.y_bottom    = corner_pixels(center_y, box_height, 1'b1);
                box.score       = product[drd_pkg::VALUE_W-1:0];
                box.class_index = best_class;
                expected_boxes.insert(expected_boxes.size(), box);
            end
            element_pos = '0;
            best_score = '0;
            best_class = '0;
        end else begin
            element_pos = element_pos + 1'b1;
        end
    endtask

    task automatic check_box(input t_box seen);
        t_box want;
        if (expected_boxes.size() == 0) begin
            report_mismatch($sformatf("unexpected box, tdata %h", seen));
        end else begin
            want = expected_boxes.pop_front();
            check_field("x_left", $signed(want.x_left), $signed(seen.x_left));
            check_field("y_top", $signed(want.y_top), $signed(seen.y_top));
            check_field("x_right", $signed(want.x_right), $signed(seen.x_right));
            check_field("y_bottom", $signed(want.y_bottom), $signed(seen.y_bottom));
            check_field("score", want.score, seen.score);
            check_field("class_index", want.class_index, seen.class_index);
            check_field("padding", want.pad, seen.pad);
        end
        boxes_checked++;
    endtask

    // The model sees the same edges as the block: register writes, accepted
    // requests on the slave side and accepted boxes on the master side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold_reg  = drd_pkg::RESET_THRESHOLD;
            row_length_reg = drd_pkg::RESET_ROW_LENGTH;
            scale_reg      = drd_pkg::RESET_SCALE;
            element_pos    = '0;
            center_x       = '0;
            center_y       = '0;
            box_width      = '0;
            box_height     = '0;
            objectness     = '0;
            best_score     = '0;
            best_class     = '0;
            expected_boxes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                apply_register(i_cfg_index, i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_element(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_box(t_box'(m_axis_tdata));
            end
        end
    end

    // Sender: bursts of random length separated by random gaps. A third of
    // the gaps are empty, which gives long stretches at full rate.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (element_queue.size() != 0) begin
                s_axis_tdata  <= element_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches at random intervals between always ready, a
    // coin toss, mostly stalled, and ready with occasional long stalls. The
    // slow patterns fill the four-entry box queue and push back on the input.
    t_ready_mode ready_mode = READY_ALWAYS;
    int          ready_hold = 0;
    int          stall_left = 0;

    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 3));
            ready_hold = $urandom_range(50, 300);
        end else begin
            ready_hold--;
        end
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            READY_SLOW:   m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) begin
                        stall_left = $urandom_range(1, 20);
                    end
                end
            end
        endcase
    end

    task automatic queue_element(input logic [drd_pkg::VALUE_W-1:0] value);
        element_queue.insert(element_queue.size(), value);
        queued_elements++;
    endtask

    task automatic write_register(input logic [drd_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [drd_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= data;
    endtask

    task automatic finish_writes;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Holds off until every queued element went in and every expected box came
    // out, then lets the box pipeline settle. The global limit covers a hang.
    task automatic wait_until_drained;
        while (element_queue.size() != 0 || s_axis_tvalid || expected_boxes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes all three registers. Row length and scale get random upper bits
    // that the block must drop.
    task automatic set_phase(input logic [drd_pkg::VALUE_W-1:0] threshold,
                             input int row_length, input int scale);
        phase_threshold = threshold;
        phase_row_length = (row_length < drd_pkg::MIN_ROW_LENGTH) ? drd_pkg::MIN_ROW_LENGTH :
                           (row_length > drd_pkg::MAX_ROW_LENGTH) ? drd_pkg::MAX_ROW_LENGTH :
                           row_length;
        write_register(drd_pkg::CFG_SCORE_THRESHOLD, threshold);
        write_register(drd_pkg::CFG_ROW_LENGTH, {8'($urandom), 8'(row_length)});
        write_register(drd_pkg::CFG_IMAGE_SCALE, {3'($urandom), 13'(scale)});
        finish_writes();
    endtask

    // A score that often lands on, just under or above the threshold.
    function automatic logic [drd_pkg::VALUE_W-1:0] score_near_threshold;
        case ($urandom_range(0, 5))
            0: return phase_threshold;
            1: return (phase_threshold == 0) ? '0 : phase_threshold - 1'b1;
            2: return '1;
            3: return 16'($urandom);
            default: return 16'($urandom_range(int'(phase_threshold), 65535));
        endcase
    endfunction

    function automatic logic [drd_pkg::VALUE_W-1:0] box_value;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // A full row of the current length. Most rows are shaped to pass or just
    // miss the threshold and share class scores for ties; some are pure noise.
    task automatic queue_random_row;
        logic [drd_pkg::VALUE_W-1:0] tie_score;
        bit                          noise;
        noise = ($urandom_range(0, 7) == 0);
        tie_score = score_near_threshold();
        for (int pos = 0; pos < phase_row_length; pos++) begin
            if (noise) begin
                queue_element(16'($urandom));
            end else if (pos < POS_OBJECTNESS) begin
                queue_element(box_value());
            end else if (pos == POS_OBJECTNESS) begin
                queue_element(score_near_threshold());
            end else begin
                case ($urandom_range(0, 6))
                    0: queue_element('0);
                    1, 2: queue_element(tie_score);
                    3: queue_element(score_near_threshold());
                    default: queue_element(16'($urandom));
                endcase
            end
        end
    endtask

    // Row length clamps up to six; maximum values; exactly at the threshold;
    // rejected by objectness; rejected by class score.
    localparam logic [drd_pkg::VALUE_W-1:0] CLAMPED_ROWS [24] = '{
        16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h4000, 16'h4000,
        16'd100,  16'd200,  16'd300,  16'd400,  16'h3FFF, 16'hFFFF,
        16'd1,    16'd2,    16'd3,    16'd4,    16'hFFFF, 16'h3FFF
    };

    // Zero threshold: a row with no class above zero still passes; then a tie.
    localparam logic [drd_pkg::VALUE_W-1:0] ZERO_THRESHOLD_ROWS [14] = '{
        16'd40000, 16'd40000, 16'd1000, 16'd1000, 16'd0,     16'd0,   16'd0,
        16'd5,     16'd6,     16'd7,    16'd8,    16'd30000, 16'd500, 16'd500
    };

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_phase(16'd16384, 3, 8191);
        foreach (CLAMPED_ROWS[i]) queue_element(CLAMPED_ROWS[i]);
        wait_until_drained();

        set_phase(16'd0, 7, 0);
        foreach (ZERO_THRESHOLD_ROWS[i]) queue_element(ZERO_THRESHOLD_ROWS[i]);
        wait_until_drained();

        // Long rows, then a shorter length written mid-row: the element after
        // the write closes the row because the position is already past it.
        set_phase(16'd8192, 255, 4096);
        repeat (9) queue_element(score_near_threshold());
        wait_until_drained();
        set_phase(16'd8192, drd_pkg::MIN_ROW_LENGTH, 640);
        queue_element(score_near_threshold());
        wait_until_drained();

        while (queued_elements < TOTAL_ELEMENTS) begin
            case ($urandom_range(0, 4))
                0: phase_threshold = '0;
                1: phase_threshold = '1;
                2: phase_threshold = drd_pkg::RESET_THRESHOLD;
                default: phase_threshold = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: phase_row_length = drd_pkg::MIN_ROW_LENGTH;
                1: phase_row_length = drd_pkg::MAX_ROW_LENGTH;
                2: phase_row_length = $urandom_range(0, drd_pkg::MIN_ROW_LENGTH - 1);
                3: phase_row_length = $urandom_range(drd_pkg::MAX_ROW_LENGTH + 1, 255);
                default: phase_row_length = $urandom_range(drd_pkg::MIN_ROW_LENGTH, 16);
            endcase
            case ($urandom_range(0, 5))
                0: set_phase(phase_threshold, phase_row_length, 1);
                1: set_phase(phase_threshold, phase_row_length, 4096);
                2: set_phase(phase_threshold, phase_row_length, 0);
                3: set_phase(phase_threshold, phase_row_length, $urandom_range(4097, 8191));
                default: set_phase(phase_threshold, phase_row_length,
                                   $urandom_range(1, 4096));
            endcase
            for (int budget = $urandom_range(60, 200); budget > 0;
                 budget -= phase_row_length) begin
                queue_random_row();
            end
            // Now and then a phase stops partway through a row, so the next
            // settings take effect on a row already in progress.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, phase_row_length - 1)) queue_element(16'($urandom));
            end
            wait_until_drained();
        end

        if (mismatch_count == 0) begin
            $display("tb_detection_row_decoder passed");
        end else begin
            $display("tb_detection_row_decoder failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run: a stuck handshake or a box that
    // never comes ends here.
    initial begin
        #(5_000_000);
        $display("tb_detection_row_decoder failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/drd_pkg.sv
rtl/drd_front.sv
rtl/drd_queue.sv
rtl/drd_back.sv
rtl/detection_row_decoder.sv
bench/tb_detection_row_decoder.sv
